>>> src/scfr_pkg.sv
// ----------------------------------------------------------------------------
// scfr_pkg
// Shared types, codes and widths of the second-chance frame replacer.
// ----------------------------------------------------------------------------
package scfr_pkg;

	localparam int FRAME_W     = 6;
	localparam int PAGE_W      = 10;
	localparam int MODE_W      = 2;
	localparam int STATUS_W    = 2;
	localparam int FRAME_SLOTS = 1 << FRAME_W;
	localparam int TDATA_W     = 24;
	localparam int TUSER_W     = 2;
	localparam int PAD_W       = TDATA_W - FRAME_W - PAGE_W - 1;

	localparam int DEF_NUM_FRAMES = 64;
	localparam int DEF_NUM_PAGES  = 1024;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;
	localparam int QCNT_W      = 2;

	// input mode codes
	localparam logic [MODE_W-1:0] MODE_ASSIGN  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ACCESS  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_REPLACE = 2'd2;

	// result status codes
	localparam logic [STATUS_W-1:0] STAT_DONE   = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_VICTIM = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_EMPTY  = 2'd2;

	typedef enum logic [1:0] {
		OP_NOP,
		OP_ASSIGN,
		OP_ACCESS,
		OP_REPLACE
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [FRAME_W-1:0] frame;
		logic [PAGE_W-1:0]  page;
		logic               write;
	} cmd_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [FRAME_W-1:0]  victim_frame;
		logic [PAGE_W-1:0]   victim_page;
		logic                write_back;
	} res_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CHECK,
		S_REPORT
	} state_t;

endpackage

>>> src/scfr_front.sv
// ----------------------------------------------------------------------------
// scfr_front
// Decode incoming words into engine commands and range-check their operands.
// ----------------------------------------------------------------------------
module scfr_front #(
	parameter int NUM_FRAMES = scfr_pkg::DEF_NUM_FRAMES,
	parameter int NUM_PAGES  = scfr_pkg::DEF_NUM_PAGES
) (
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [scfr_pkg::TDATA_W-1:0] s_tdata,   // frame, page, write
	input  logic [scfr_pkg::TUSER_W-1:0] s_tuser,   // mode
	input  logic                         q_ready,
	output logic                         push,
	output scfr_pkg::cmd_t               cmd
);
	import scfr_pkg::*;

	logic [FRAME_W-1:0] frame;
	logic [PAGE_W-1:0]  page;
	logic               frame_ok;
	logic               page_ok;

	assign frame    = s_tdata[FRAME_W-1:0];
	assign page     = s_tdata[FRAME_W+PAGE_W-1:FRAME_W];
	assign frame_ok = 32'(frame) < 32'(NUM_FRAMES);
	assign page_ok  = 32'(page) < 32'(NUM_PAGES);

	assign s_tready = q_ready;
	assign push     = s_tvalid && q_ready;

	always_comb begin
		cmd.frame = frame;
		cmd.page  = page;
		cmd.write = s_tdata[FRAME_W+PAGE_W];
		unique case (s_tuser)
			MODE_ASSIGN:  cmd.op = (frame_ok && page_ok) ? OP_ASSIGN : OP_NOP;
			MODE_ACCESS:  cmd.op = frame_ok ? OP_ACCESS : OP_NOP;
			MODE_REPLACE: cmd.op = OP_REPLACE;
			default:      cmd.op = OP_NOP;
		endcase
	end

endmodule

>>> src/scfr_queue.sv
// ----------------------------------------------------------------------------
// scfr_queue
// Two-entry command queue between the decoder and the replacement engine.
// ----------------------------------------------------------------------------
module scfr_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  scfr_pkg::cmd_t push_cmd,
	output logic           ready,
	input  logic           pop,
	output logic           valid,
	output scfr_pkg::cmd_t head_cmd
);
	import scfr_pkg::*;

	cmd_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] fill_q;

	assign ready    = fill_q != QCNT_W'(QUEUE_DEPTH);
	assign valid    = fill_q != '0;
	assign head_cmd = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			fill_q <= fill_q + QCNT_W'(push) - QCNT_W'(pop);
		end
	end

endmodule

>>> src/scfr_back.sv
// ----------------------------------------------------------------------------
// scfr_back
// Replacement engine: arrival ring, page table, reference and dirty bits,
// second-chance scan and result register.
// ----------------------------------------------------------------------------
module scfr_back #(
	parameter int NUM_FRAMES = scfr_pkg::DEF_NUM_FRAMES
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	input  scfr_pkg::cmd_t cmd,
	output logic           cmd_pop,
	output logic           out_valid,
	input  logic           out_ready,
	output scfr_pkg::res_t res
);
	import scfr_pkg::*;

	localparam int RING_AW = $clog2(NUM_FRAMES);
	localparam int COUNT_W = $clog2(NUM_FRAMES + 1);

	function automatic logic [RING_AW-1:0] ring_inc(input logic [RING_AW-1:0] p);
		return (p == RING_AW'(NUM_FRAMES - 1)) ? '0 : p + 1'b1;
	endfunction

	state_t state_q, state_d;

	logic [FRAME_W-1:0] ring_mem [NUM_FRAMES];
	logic [PAGE_W-1:0]  page_mem [FRAME_SLOTS];
	logic [FRAME_W-1:0] ring_rd_q;
	logic [PAGE_W-1:0]  page_rd_q;

	logic [FRAME_SLOTS-1:0] ref_q;
	logic [FRAME_SLOTS-1:0] dirty_q;

	logic [RING_AW-1:0] head_q, head_d;
	logic [RING_AW-1:0] tail_q, tail_d;
	logic [COUNT_W-1:0] count_q, count_d;
	logic [FRAME_W-1:0] victim_q, victim_d;
	logic               wb_q, wb_d;

	logic               out_valid_q;
	res_t               res_q, res_d;
	logic               out_free;
	logic               out_load;

	logic               ring_we, ring_re;
	logic [RING_AW-1:0] ring_wa, ring_ra;
	logic [FRAME_W-1:0] ring_wd;
	logic               page_we, page_re;
	logic [FRAME_W-1:0] page_addr;
	logic               ref_we, ref_wd;
	logic [FRAME_W-1:0] ref_wa;
	logic               dirty_we, dirty_wd;
	logic [FRAME_W-1:0] dirty_wa;
	logic [FRAME_W-1:0] slot_frame;

	assign out_free   = !out_valid_q || out_ready;
	assign out_valid  = out_valid_q;
	assign res        = res_q;
	assign slot_frame = ring_rd_q;

	always_comb begin
		state_d  = state_q;
		cmd_pop  = 1'b0;
		out_load = 1'b0;
		res_d    = '0;
		ring_we  = 1'b0;
		ring_wa  = tail_q;
		ring_wd  = cmd.frame;
		ring_re  = 1'b0;
		ring_ra  = head_q;
		page_we  = 1'b0;
		page_re  = 1'b0;
		page_addr = cmd.frame;
		ref_we   = 1'b0;
		ref_wa   = cmd.frame;
		ref_wd   = 1'b0;
		dirty_we = 1'b0;
		dirty_wa = cmd.frame;
		dirty_wd = 1'b0;
		head_d   = head_q;
		tail_d   = tail_q;
		count_d  = count_q;
		victim_d = victim_q;
		wb_d     = wb_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd_valid && out_free) begin
					cmd_pop      = 1'b1;
					out_load     = 1'b1;
					res_d.status = STAT_DONE;
					unique case (cmd.op)
						OP_NOP: begin
						end
						OP_ASSIGN: begin
							if (count_q != COUNT_W'(NUM_FRAMES)) begin
								ring_we  = 1'b1;
								page_we  = 1'b1;
								ref_we   = 1'b1;
								dirty_we = 1'b1;
								tail_d   = ring_inc(tail_q);
								count_d  = count_q + 1'b1;
							end
						end
						OP_ACCESS: begin
							ref_we   = 1'b1;
							ref_wd   = 1'b1;
							dirty_we = cmd.write;
							dirty_wd = 1'b1;
						end
						OP_REPLACE: begin
							if (count_q == '0) begin
								res_d.status = STAT_EMPTY;
							end else begin
								// fetch the oldest frame, result follows the scan
								out_load = 1'b0;
								ring_re  = 1'b1;
								state_d  = S_CHECK;
							end
						end
					endcase
				end
			end
			S_CHECK: begin
				if (ref_q[slot_frame]) begin
					// second chance: clear, rotate to the tail, look at the next one
					ref_we  = 1'b1;
					ref_wa  = slot_frame;
					ring_we = 1'b1;
					ring_wd = slot_frame;
					tail_d  = ring_inc(tail_q);
					head_d  = ring_inc(head_q);
					ring_re = 1'b1;
					ring_ra = head_d;
				end else begin
					page_re   = 1'b1;
					page_addr = slot_frame;
					victim_d  = slot_frame;
					wb_d      = dirty_q[slot_frame];
					head_d    = ring_inc(head_q);
					count_d   = count_q - 1'b1;
					state_d   = S_REPORT;
				end
			end
			S_REPORT: begin
				if (out_free) begin
					out_load           = 1'b1;
					res_d.status       = STAT_VICTIM;
					res_d.victim_frame = victim_q;
					res_d.victim_page  = page_rd_q;
					res_d.write_back   = wb_q;
					state_d            = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// ring memory: one write and one read port, read data bypassed on a clash
	always_ff @(posedge clk) begin
		if (ring_we) begin
			ring_mem[ring_wa] <= ring_wd;
		end
		if (ring_re) begin
			ring_rd_q <= (ring_we && ring_wa == ring_ra) ? ring_wd : ring_mem[ring_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (page_we) begin
			page_mem[page_addr] <= cmd.page;
		end
		if (page_re) begin
			page_rd_q <= page_mem[page_addr];
		end
	end

	always_ff @(posedge clk) begin
		victim_q <= victim_d;
		wb_q     <= wb_d;
		if (out_load) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			ref_q       <= '0;
			dirty_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
			count_q <= count_d;
			if (ref_we) begin
				ref_q[ref_wa] <= ref_wd;
			end
			if (dirty_we) begin
				dirty_q[dirty_wa] <= dirty_wd;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_W'(NUM_FRAMES))
		else $error("ring count beyond frame total");

	a_empty_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (head_q == tail_q))
		else $error("empty ring with head and tail apart");

	a_scan_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHECK) |-> (count_q != '0))
		else $error("scan running on an empty ring");

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> (state_q == S_IDLE && !(out_valid_q && !out_ready)))
		else $error("command taken while engine busy");

	a_report_victim: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_REPORT && out_free) |=> (out_valid_q && res_q.status == STAT_VICTIM))
		else $error("victim report lost");
`endif

endmodule

>>> src/second_chance_frame_replacer.sv
// ----------------------------------------------------------------------------
// second_chance_frame_replacer: second-chance page replacement over a FIFO ring
// Assign, access, ignored words, empty replace: queue entry, result register, m_tvalid.
// Replace: queue entry, head fetch, one frame scanned a cycle, page read, result register.
// Throughput: one single-step word a cycle while m_tready is high and no replace runs.
// Reset (arst_n low): ring empty, all reference and dirty bits clear, no results.
// ----------------------------------------------------------------------------
module second_chance_frame_replacer #(
	parameter int NUM_FRAMES = scfr_pkg::DEF_NUM_FRAMES,
	parameter int NUM_PAGES  = scfr_pkg::DEF_NUM_PAGES
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// input words
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [scfr_pkg::TDATA_W-1:0] s_tdata,  // [5:0] frame, [15:6] page, [16] write
	input  logic [scfr_pkg::TUSER_W-1:0] s_tuser,  // [1:0] mode
	// result words
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [scfr_pkg::TDATA_W-1:0] m_tdata,  // [5:0] victim_frame, [15:6] victim_page,
	                                               // [16] write_back
	output logic [scfr_pkg::TUSER_W-1:0] m_tuser   // [1:0] status
);
	import scfr_pkg::*;

	// Front end: decode the mode and range-check frame and page. Out-of-range
	// assigns and accesses, and the unused mode, become no-ops that still
	// return a done word.
	cmd_t front_cmd;
	logic front_push;
	logic q_ready;

	// Queue to engine
	cmd_t q_cmd;
	logic q_valid;
	logic q_pop;

	res_t res;

	scfr_front #(
		.NUM_FRAMES (NUM_FRAMES),
		.NUM_PAGES  (NUM_PAGES)
	) u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_ready  (q_ready),
		.push     (front_push),
		.cmd      (front_cmd)
	);

	// Short queue: lets the front keep accepting words, up to its two entries, while the engine is
	// busy scanning for a victim.
	scfr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (front_push),
		.push_cmd (front_cmd),
		.ready    (q_ready),
		.pop      (q_pop),
		.valid    (q_valid),
		.head_cmd (q_cmd)
	);

	// Engine: assign and access finish in the idle state; replace fetches the head of the
	// ring, rotates referenced frames to the tail one per cycle, then reads
	// the victim's page and reports it from the result register.
	scfr_back #(
		.NUM_FRAMES (NUM_FRAMES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_valid),
		.cmd       (q_cmd),
		.cmd_pop   (q_pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.res       (res)
	);

	// Pack the result word, zero-filled to whole bytes
	assign m_tdata = {{PAD_W{1'b0}}, res.write_back, res.victim_page, res.victim_frame};
	assign m_tuser = res.status;

endmodule
